// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants
// Widths of the adjugate, determinant and divider datapaths of the 3x3 inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

   localparam int ELEM_W    = 24;
   localparam int NUM_ELEMS = 9;
   localparam int PROD_W    = 2 * ELEM_W;          // element * element
   localparam int ADJ_W     = PROD_W + 1;          // difference of two products
   localparam int ADJ_MAG_W = PROD_W;              // |adj| <= 2^47
   localparam int DET_W     = 74;                  // |det| <= 3 * 2^70
   localparam int DMAG_W    = DET_W - 1;
   localparam int THR_W     = 40;
   localparam logic [THR_W-1:0] THR_RESET = 40'd2814749767;
   localparam int DIV_STEPS = ELEM_W + 1;          // quotient bits 24..0
   localparam int Q_W       = DIV_STEPS + 1;       // after rounding
   localparam int DIV_LAT   = DIV_STEPS + 2;       // entry, bit steps, round
   localparam logic [ELEM_W-1:0] POS_LIMIT = 24'h7FFFFF;
   localparam logic [ELEM_W-1:0] NEG_LIMIT = 24'h800000;

   typedef logic signed [ELEM_W-1:0] elem_type;

   typedef struct packed {
      logic                 neg;
      logic [ADJ_MAG_W-1:0] mag;
   } lane_in_type;

   typedef struct packed {
      logic           neg;
      logic           ovf;
      logic [Q_W-1:0] q;
   } lane_res_type;

   typedef struct packed {
      logic valid;
      logic singular;
   } ctrl_type;

endpackage

// ===== rtl/mi3_front.sv =====
// ----------------------------------------------------------------------------
// mi3_front: adjugate and determinant
// Six register stages: products, adjugate, split multiplies, terms,
// determinant, then magnitude, sign and singular test.
// ----------------------------------------------------------------------------
module mi3_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  mi3_pkg::elem_type            a [mi3_pkg::NUM_ELEMS],
   input  logic [mi3_pkg::THR_W-1:0]    threshold,
   output mi3_pkg::ctrl_type            out_ctrl,
   output logic [mi3_pkg::DMAG_W-1:0]   out_den,
   output mi3_pkg::lane_in_type         out_lane [mi3_pkg::NUM_ELEMS]
);

   localparam int N  = mi3_pkg::NUM_ELEMS;
   localparam int PW = mi3_pkg::PROD_W;
   localparam int AW = mi3_pkg::ADJ_W;
   localparam int DW = mi3_pkg::DET_W;
   localparam int LW = mi3_pkg::ELEM_W;
   localparam int HW = AW - LW;

   // adj[k] = a[PA]*a[PB] - a[MA]*a[MB]
   localparam logic [3:0] PA [N] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
   localparam logic [3:0] PB [N] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
   localparam logic [3:0] MA [N] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
   localparam logic [3:0] MB [N] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};
   // row 0 cofactor expansion uses adj[0], adj[3], adj[6]
   localparam logic [3:0] CI [3] = '{4'd0, 4'd3, 4'd6};

   logic [4:0]                 vld_ff;
   logic signed [PW-1:0]       pp_ff [N];
   logic signed [PW-1:0]       pm_ff [N];
   mi3_pkg::elem_type          row1_ff [3];
   mi3_pkg::elem_type          row2_ff [3];
   logic signed [AW-1:0]       adj2_ff [N];
   logic signed [AW-1:0]       adj3_ff [N];
   logic signed [AW-1:0]       adj4_ff [N];
   logic signed [AW-1:0]       adj5_ff [N];
   logic signed [LW+LW:0]      plo_ff [3];
   logic signed [LW+HW-1:0]    phi_ff [3];
   logic signed [DW-1:0]       term_ff [3];
   logic signed [DW-1:0]       det_ff;
   logic signed [DW-1:0]       det_abs;
   mi3_pkg::ctrl_type          ctrl_ff;
   logic [mi3_pkg::DMAG_W-1:0] den_ff;
   mi3_pkg::lane_in_type       lane_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < N; k++) begin
            pp_ff[k] <= a[PA[k]] * a[PB[k]];
            pm_ff[k] <= a[MA[k]] * a[MB[k]];
         end
         for (int i = 0; i < 3; i++) begin
            row1_ff[i] <= a[i];
            row2_ff[i] <= row1_ff[i];
         end
         for (int k = 0; k < N; k++) begin
            adj2_ff[k] <= AW'(pp_ff[k]) - AW'(pm_ff[k]);
            adj3_ff[k] <= adj2_ff[k];
            adj4_ff[k] <= adj3_ff[k];
            adj5_ff[k] <= adj4_ff[k];
         end
         // 24 x 49 split into a low unsigned and a high signed partial product
         for (int i = 0; i < 3; i++) begin
            plo_ff[i] <= row2_ff[i] * $signed({1'b0, adj2_ff[CI[i]][LW-1:0]});
            phi_ff[i] <= row2_ff[i] * $signed(adj2_ff[CI[i]][AW-1:LW]);
            term_ff[i] <= (DW'(phi_ff[i]) <<< LW) + DW'(plo_ff[i]);
         end
         det_ff <= term_ff[0] + term_ff[1] + term_ff[2];
      end
   end

   always_comb begin
      det_abs = det_ff[DW-1] ? -det_ff : det_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff.valid <= 1'b0;
      end else if (en) begin
         ctrl_ff.valid <= vld_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctrl_ff.singular <= (det_abs == '0) ||
                             (det_abs[mi3_pkg::DMAG_W-1:0] <
                              mi3_pkg::DMAG_W'(threshold));
         den_ff <= det_abs[mi3_pkg::DMAG_W-1:0];
         for (int k = 0; k < N; k++) begin
            lane_ff[k].neg <= adj5_ff[k][AW-1] ^ det_ff[DW-1];
            lane_ff[k].mag <= adj5_ff[k][AW-1] ? mi3_pkg::ADJ_MAG_W'(-adj5_ff[k])
                                               : mi3_pkg::ADJ_MAG_W'(adj5_ff[k]);
         end
      end
   end

   assign out_ctrl = ctrl_ff;
   assign out_den  = den_ff;
   assign out_lane = lane_ff;

endmodule

// ===== rtl/mi3_div_lane.sv =====
// ----------------------------------------------------------------------------
// mi3_div_lane: pipelined restoring divider, one result element
// Overflow check, one quotient bit per stage, then round half away from zero.
// ----------------------------------------------------------------------------
module mi3_div_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        en,
   input  mi3_pkg::lane_in_type        lane_in,
   input  logic [mi3_pkg::DMAG_W-1:0]  den,
   output mi3_pkg::lane_res_type       lane_res
);

   localparam int STEPS = mi3_pkg::DIV_STEPS;
   localparam int NUM_W = mi3_pkg::ADJ_MAG_W + 2 * FRAC_BITS;
   localparam int DEN_W = mi3_pkg::DMAG_W + STEPS;
   localparam int CMP_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;

   logic [CMP_W-1:0]          rem_ff [STEPS+1];
   logic [mi3_pkg::DMAG_W-1:0] den_ff [STEPS+1];
   logic [STEPS-1:0]          q_ff   [STEPS+1];
   logic                      ovf_ff [STEPS+1];
   logic                      neg_ff [STEPS+1];
   logic [CMP_W-1:0]          num_ext;
   logic                      round_up;
   mi3_pkg::lane_res_type     res_ff;

   always_comb begin
      num_ext  = CMP_W'(lane_in.mag) << (2 * FRAC_BITS);
      round_up = (rem_ff[STEPS] << 1) >= CMP_W'(den_ff[STEPS]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_ext;
         den_ff[0] <= den;
         q_ff[0]   <= '0;
         ovf_ff[0] <= num_ext >= (CMP_W'(den) << STEPS);
         neg_ff[0] <= lane_in.neg;
      end
   end

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int B = STEPS - 1 - k;
      logic [CMP_W-1:0] sub;
      logic             ge;
      always_comb begin
         sub = CMP_W'(den_ff[k]) << B;
         ge  = rem_ff[k] >= sub;
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]    <= ge ? rem_ff[k] - sub : rem_ff[k];
            q_ff[k+1]      <= q_ff[k] | (STEPS'(ge) << B);
            den_ff[k+1]    <= den_ff[k];
            ovf_ff[k+1]    <= ovf_ff[k];
            neg_ff[k+1]    <= neg_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff.q   <= mi3_pkg::Q_W'(q_ff[STEPS]) + mi3_pkg::Q_W'(round_up);
         res_ff.ovf <= ovf_ff[STEPS];
         res_ff.neg <= neg_ff[STEPS];
      end
   end

   assign lane_res = res_ff;

endmodule

// ===== rtl/mi3_merge.sv =====
// ----------------------------------------------------------------------------
// mi3_merge: saturation, singular masking and output skid
// Combines the nine lane quotients into one response with a skid register.
// ----------------------------------------------------------------------------
module mi3_merge (
   input  logic                    clock,
   input  logic                    reset,
   input  mi3_pkg::ctrl_type       in_ctrl,
   input  mi3_pkg::lane_res_type   lane_res [mi3_pkg::NUM_ELEMS],
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output mi3_pkg::elem_type       rsp_r [mi3_pkg::NUM_ELEMS],
   output logic                    rsp_singular,
   output logic                    pipe_en
);

   localparam int N = mi3_pkg::NUM_ELEMS;

   mi3_pkg::elem_type res_in [N];
   mi3_pkg::elem_type out_r_ff [N];
   mi3_pkg::elem_type skid_r_ff [N];
   logic              out_valid_ff;
   logic              out_sing_ff;
   logic              skid_valid_ff;
   logic              skid_sing_ff;
   logic              incoming;
   logic              take;
   logic              out_free;

   always_comb begin
      logic [mi3_pkg::ELEM_W-1:0] lim;
      logic [mi3_pkg::ELEM_W-1:0] mag;
      for (int k = 0; k < N; k++) begin
         lim = lane_res[k].neg ? mi3_pkg::NEG_LIMIT : mi3_pkg::POS_LIMIT;
         mag = (lane_res[k].ovf || (lane_res[k].q > mi3_pkg::Q_W'(lim)))
               ? lim : lane_res[k].q[mi3_pkg::ELEM_W-1:0];
         if (in_ctrl.singular) begin
            res_in[k] = '0;
         end else begin
            res_in[k] = lane_res[k].neg ? -$signed(mag) : $signed(mag);
         end
      end
   end

   assign pipe_en  = !skid_valid_ff;
   assign incoming = pipe_en && in_ctrl.valid;
   assign take     = out_valid_ff && rsp_ready;
   assign out_free = !out_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff || incoming;
         skid_valid_ff <= 1'b0;
      end else if (incoming) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_r_ff    <= skid_valid_ff ? skid_r_ff : res_in;
         out_sing_ff <= skid_valid_ff ? skid_sing_ff : in_ctrl.singular;
      end else if (incoming) begin
         skid_r_ff    <= res_in;
         skid_sing_ff <= in_ctrl.singular;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_r        = out_r_ff;
   assign rsp_singular = out_sing_ff;

   skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a request while output register is empty");

   stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready && incoming) |=> skid_valid_ff)
      else $error("stalled request was dropped");

   singular_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_sing_ff) |->
         (out_r_ff[0] == '0 && out_r_ff[4] == '0 && out_r_ff[8] == '0))
      else $error("singular response carries nonzero elements");

endmodule

// ===== rtl/matrix_inverse_3x3_core.sv =====
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core: 3x3 fixed-point matrix inverse by adjugate
// Accepts one matrix per clock while req_ready is high and raises rsp_valid
// for each matrix taken. Six stages form the adjugate and the exact
// determinant; nine divider lanes, one per result element, each take an
// overflow-check entry stage, resolve one quotient bit per stage over 25
// stages and round in a last stage (27 in all); a final stage saturates,
// zeroes singular responses and feeds a skid register. Throughput is one
// request per cycle whenever the response side keeps up; once a stalled
// response fills the skid register the whole pipeline and req_ready hold
// until it drains. csr_ready is always high.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [39:0]          csr_singular_threshold,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic signed [23:0]   req_a00,
   input  logic signed [23:0]   req_a01,
   input  logic signed [23:0]   req_a02,
   input  logic signed [23:0]   req_a10,
   input  logic signed [23:0]   req_a11,
   input  logic signed [23:0]   req_a12,
   input  logic signed [23:0]   req_a20,
   input  logic signed [23:0]   req_a21,
   input  logic signed [23:0]   req_a22,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [23:0]   rsp_r00,
   output logic signed [23:0]   rsp_r01,
   output logic signed [23:0]   rsp_r02,
   output logic signed [23:0]   rsp_r10,
   output logic signed [23:0]   rsp_r11,
   output logic signed [23:0]   rsp_r12,
   output logic signed [23:0]   rsp_r20,
   output logic signed [23:0]   rsp_r21,
   output logic signed [23:0]   rsp_r22,
   output logic                 rsp_singular
);

   localparam int N = mi3_pkg::NUM_ELEMS;

   logic [mi3_pkg::THR_W-1:0]  thr_ff;
   logic                       pipe_en;
   mi3_pkg::elem_type          a [N];
   mi3_pkg::elem_type          r [N];
   mi3_pkg::ctrl_type          front_ctrl;
   logic [mi3_pkg::DMAG_W-1:0] den;
   mi3_pkg::lane_in_type       lane_in [N];
   mi3_pkg::lane_res_type      lane_res [N];
   mi3_pkg::ctrl_type          ctrl_ff [mi3_pkg::DIV_LAT];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= mi3_pkg::THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_singular_threshold;
      end
   end

   assign req_ready = pipe_en;

   assign a = '{req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
                req_a20, req_a21, req_a22};

   mi3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_valid),
      .a         (a),
      .threshold (thr_ff),
      .out_ctrl  (front_ctrl),
      .out_den   (den),
      .out_lane  (lane_in)
   );

   for (genvar k = 0; k < N; k++) begin : g_lane
      mi3_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock    (clock),
         .en       (pipe_en),
         .lane_in  (lane_in[k]),
         .den      (den),
         .lane_res (lane_res[k])
      );
   end

   // control rides alongside the divider lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mi3_pkg::DIV_LAT; i++) begin
            ctrl_ff[i] <= '0;
         end
      end else if (pipe_en) begin
         ctrl_ff[0] <= front_ctrl;
         for (int i = 1; i < mi3_pkg::DIV_LAT; i++) begin
            ctrl_ff[i] <= ctrl_ff[i-1];
         end
      end
   end

   mi3_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .in_ctrl      (ctrl_ff[mi3_pkg::DIV_LAT-1]),
      .lane_res     (lane_res),
      .rsp_ready    (rsp_ready),
      .rsp_valid    (rsp_valid),
      .rsp_r        (r),
      .rsp_singular (rsp_singular),
      .pipe_en      (pipe_en)
   );

   assign rsp_r00 = r[0];
   assign rsp_r01 = r[1];
   assign rsp_r02 = r[2];
   assign rsp_r10 = r[3];
   assign rsp_r11 = r[4];
   assign rsp_r12 = r[5];
   assign rsp_r20 = r[6];
   assign rsp_r21 = r[7];
   assign rsp_r22 = r[8];

endmodule
